### hw/rtl/sma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple moving average package
// Shared constants, register map and controller state codes for the
// simple moving average block.
// ----------------------------------------------------------------------------
package sma_pkg;

  // Default sizing of the block.
  localparam int WINDOW_MAX_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 32;

  // Fixed port widths.
  localparam int PRICE_W   = 32;
  localparam int AVG_W     = 32;
  localparam int WIN_REG_W = 9;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Register map (byte addresses).
  localparam logic [PADDR_W-1:0] ADDR_WINDOW_LENGTH = 3'd0;

  // Value of the window length register after reset.
  localparam logic [WIN_REG_W-1:0] WINDOW_LENGTH_RST = 9'd1;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

endpackage

### hw/rtl/simple_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple moving average with warm-up
// Mean of the most recent window_length price samples, or of every sample so
// far while the window is still filling. Bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one price sample and a
//   first_of_series flag per transaction; a set flag restarts the warm-up.
//   The output channel (out_valid / out_stall) carries one average per input. The
//   user writes window_length over the APB port at address 0 while the block is
//   idle (not enforced); 0 acts as 1, values above WINDOW_MAX as WINDOW_MAX.
// Timing:
//   A sample passes through READ, UPDATE, DIV and DONE before the next one is
//   accepted; the sum is SUM_W = SAMPLE_BITS + log2(WINDOW_MAX) bits wide. The
//   running-sum update spans READ and UPDATE around the sample ring's
//   registered read port, and the quotient is produced in DIV by a divider
//   that retires one quotient bit per cycle.
// Reset:
//   rst clears the running sum, the fill count, the write pointer and the
//   output valid flag, and sets window_length to 1. The sample ring is not
//   cleared; only entries written since the last restart ever enter the sum.
// Back-pressure:
//   A finished average sits in the output register until it is taken, while
//   the next sample is accepted. If the output register is still full when
//   the next average is ready, the controller waits and in_stall stays high.
// ----------------------------------------------------------------------------
module simple_moving_average #(
  parameter int WINDOW_MAX  = sma_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,

  // Sample input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sma_pkg::PRICE_W-1:0]  price,
  input  logic                         first_of_series,

  // Average output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sma_pkg::AVG_W-1:0]    average,

  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sma_pkg::PADDR_W-1:0]  paddr,
  input  logic [sma_pkg::PDATA_W-1:0]  pwdata,
  output logic [sma_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W = SAMPLE_BITS + CNT_W - 1;
  localparam int BIT_W = $clog2(SUM_W);
  localparam int OFS_W = CNT_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [sma_pkg::WIN_REG_W-1:0] window_length;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr == sma_pkg::ADDR_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= sma_pkg::WINDOW_LENGTH_RST;
    end else if (cfg_write) begin
      window_length <= pwdata[sma_pkg::WIN_REG_W-1:0];
    end
  end

  always_comb begin
    if (paddr == sma_pkg::ADDR_WINDOW_LENGTH) begin
      prdata = sma_pkg::PDATA_W'(window_length);
    end else begin
      prdata = '0;
    end
  end

  // Effective window, clamped to the range 1 .. WINDOW_MAX.
  logic [CNT_W-1:0] win_eff;

  always_comb begin
    if (window_length == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = CNT_W'(window_length);
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath state
  // ---------------------------------------------------------------------------
  sma_pkg::state_t state;

  logic [SAMPLE_BITS-1:0] sample;
  logic [SUM_W-1:0]       running_sum;
  logic [CNT_W-1:0]       fill_count;
  logic [PTR_W-1:0]       write_pointer;
  logic                   full;
  logic [SAMPLE_BITS-1:0] oldest_data;
  logic [SUM_W-1:0]       quot;
  logic [CNT_W-1:0]       rem;
  logic [BIT_W-1:0]       bit_cnt;
  logic [sma_pkg::AVG_W-1:0] avg;
  logic                   avg_valid;

  logic                   accept;
  logic                   win_full;
  logic [OFS_W-1:0]       oldest_ofs;
  logic [PTR_W-1:0]       oldest_addr;
  logic [SUM_W-1:0]       sum_next;
  logic [OFS_W-1:0]       trial;
  logic                   trial_ge;
  logic [CNT_W-1:0]       rem_next;
  logic                   out_free;

  assign in_stall  = (state != sma_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign win_full  = (fill_count >= win_eff);
  assign out_valid = avg_valid;
  assign average   = avg;
  assign out_free  = !avg_valid || !out_stall;

  // Position of the oldest sample still in the sum, modulo WINDOW_MAX.
  always_comb begin
    oldest_ofs = OFS_W'(write_pointer) + OFS_W'(WINDOW_MAX) - OFS_W'(fill_count);
    if (oldest_ofs >= OFS_W'(WINDOW_MAX)) begin
      oldest_ofs = oldest_ofs - OFS_W'(WINDOW_MAX);
    end
    oldest_addr = PTR_W'(oldest_ofs);
  end

  // The sample was already added; the oldest one leaves once the window is full.
  assign sum_next = full ? (running_sum - SUM_W'(oldest_data)) : running_sum;

  // One restoring step: the remainder always stays below the divisor.
  always_comb begin
    trial    = {rem, quot[SUM_W-1]};
    trial_ge = (trial >= OFS_W'(fill_count));
    if (trial_ge) begin
      rem_next = CNT_W'(trial - OFS_W'(fill_count));
    end else begin
      rem_next = CNT_W'(trial);
    end
  end

  // ---------------------------------------------------------------------------
  // Sample ring
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];

  always_ff @(posedge clk) begin
    if (state == sma_pkg::S_UPDATE) begin
      ring[write_pointer] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sma_pkg::S_READ) begin
      oldest_data <= ring[oldest_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Controller and running state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sma_pkg::S_IDLE;
      running_sum   <= '0;
      fill_count    <= '0;
      write_pointer <= '0;
      avg_valid     <= 1'b0;
    end else begin
      if ((state == sma_pkg::S_DONE) && out_free) begin
        avg_valid <= 1'b1;
      end else if (!out_stall) begin
        avg_valid <= 1'b0;
      end

      case (state)
        sma_pkg::S_IDLE: begin
          if (accept) begin
            if (first_of_series) begin
              running_sum   <= '0;
              fill_count    <= '0;
              write_pointer <= '0;
            end
            state <= sma_pkg::S_READ;
          end
        end

        sma_pkg::S_READ: begin
          running_sum <= running_sum + SUM_W'(sample);
          if (!win_full) begin
            fill_count <= fill_count + CNT_W'(1);
          end
          state <= sma_pkg::S_UPDATE;
        end

        sma_pkg::S_UPDATE: begin
          running_sum <= sum_next;
          if (32'(write_pointer) == WINDOW_MAX - 1) begin
            write_pointer <= '0;
          end else begin
            write_pointer <= write_pointer + PTR_W'(1);
          end
          state <= sma_pkg::S_DIV;
        end

        sma_pkg::S_DIV: begin
          if (bit_cnt == '0) begin
            state <= sma_pkg::S_DONE;
          end
        end

        sma_pkg::S_DONE: begin
          if (out_free) begin
            state <= sma_pkg::S_IDLE;
          end
        end

        default: begin
          state <= sma_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk) begin
    case (state)
      sma_pkg::S_IDLE: begin
        if (accept) begin
          sample <= SAMPLE_BITS'(price);
        end
      end

      sma_pkg::S_READ: begin
        full <= win_full;
      end

      sma_pkg::S_UPDATE: begin
        quot    <= sum_next;
        rem     <= '0;
        bit_cnt <= BIT_W'(SUM_W - 1);
      end

      sma_pkg::S_DIV: begin
        quot    <= {quot[SUM_W-2:0], trial_ge};
        rem     <= rem_next;
        bit_cnt <= bit_cnt - BIT_W'(1);
      end

      sma_pkg::S_DONE: begin
        if (out_free) begin
          avg <= sma_pkg::AVG_W'(quot);
        end
      end

      default: begin
        sample <= sample;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == sma_pkg::S_READ))
    else $error("accepted sample did not start the sum update");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == sma_pkg::S_DIV) |-> (fill_count != '0))
    else $error("division started with an empty window");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == sma_pkg::S_DIV) |-> (rem < fill_count))
    else $error("divider remainder reached the divisor");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= WINDOW_MAX)
    else $error("fill count above the ring depth");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    ((state == sma_pkg::S_DONE) && out_free) |=> out_valid && !in_stall)
    else $error("finished average was not presented");

endmodule
